@@ hw/rtl/i2a_pkg.sv @@
`default_nettype none

package i2a_pkg;

	localparam int VALUE_BITS = 32;
	localparam int IN_BITS    = 32;

	function automatic int dec_digits_f(input int bits);
		logic [67:0] mx;
		logic [67:0] p;
		int          n;
		mx = (68'd1 << bits) - 68'd1;
		p  = 68'd1;
		n  = 0;
		for (int i = 0; i < 21; i++) begin
			if (p <= mx) begin
				n = i + 1;
			end
			p = p * 68'd10;
		end
		return n;
	endfunction

	localparam int DEC_DIGITS = dec_digits_f(VALUE_BITS);
	localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
	localparam int BCD_BITS   = DEC_DIGITS * 4;
	localparam int DIG_W      = (DEC_DIGITS > 1) ? $clog2(DEC_DIGITS) : 1;
	localparam int CNT_W      = $clog2(VALUE_BITS + 1);
	localparam int Q_DEPTH    = 2;

	localparam logic [1:0] FN_UNSIGNED = 2'd0;
	localparam logic [1:0] FN_SIGNED   = 2'd1;
	localparam logic [1:0] FN_HEX      = 2'd2;
	localparam int         FN_HEX_BIT  = 1;

	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_LETTER = 8'h57;
	localparam logic [7:0] CH_MINUS  = 8'h2d;

	typedef struct packed {
		logic [IN_BITS-1:0] value;
		logic [1:0]         func;
	} val_word_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} chr_word_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] mag;
		logic                  neg;
		logic                  hex;
	} cmd_t;

	function automatic logic [7:0] digit_char_f(input logic [3:0] d);
		return (d < 4'd10) ? (CH_ZERO + {4'd0, d}) : (CH_LETTER + {4'd0, d});
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/i2a_front.sv @@
`default_nettype none

module i2a_front
	import i2a_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      val_valid,
	output logic           val_stall,
	input  wire val_word_t val_word,
	output logic           push,
	output cmd_t           push_cmd,
	input  wire logic      full
);

	logic [VALUE_BITS-1:0] v;
	logic                  neg;
	logic                  hex;

	assign v   = VALUE_BITS'(val_word.value);
	assign hex = val_word.func[FN_HEX_BIT];
	assign neg = (val_word.func == FN_SIGNED) && v[VALUE_BITS-1];

	assign val_stall = full;
	assign push      = val_valid && !full;

	always_comb begin
		push_cmd.mag = neg ? (~v + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : v;
		push_cmd.neg = neg;
		push_cmd.hex = hex;
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

endmodule

`default_nettype wire

@@ hw/rtl/i2a_queue.sv @@
`default_nettype none

module i2a_queue
	import i2a_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	input  wire logic pop,
	output logic      pop_valid,
	output cmd_t      pop_cmd
);

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QC_W  = $clog2(Q_DEPTH + 1);

	cmd_t             ent_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [QC_W-1:0]  cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (cnt_q == QC_W'(Q_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_cmd   = ent_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_ptrs_track_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || full) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

@@ hw/rtl/i2a_back.sv @@
`default_nettype none

module i2a_back
	import i2a_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output logic      pop,
	output logic      chr_valid,
	input  wire logic chr_stall,
	output chr_word_t chr_word
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CONV = 5'b00010,
		ST_FIND = 5'b00100,
		ST_SIGN = 5'b01000,
		ST_EMIT = 5'b10000
	} bk_state_t;

	bk_state_t             state_q;
	logic [VALUE_BITS-1:0] bin_q;
	logic [BCD_BITS-1:0]   bcd_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIG_W-1:0]      dig_q;
	logic                  neg_q;
	logic                  chr_valid_q;
	chr_word_t             chr_word_q;

	logic                  free;
	logic [BCD_BITS-1:0]   bcd_adj;
	logic [DIG_W-1:0]      top_dig;
	logic [3:0]            nib;
	logic                  last_dig;

	assign free      = !chr_valid_q || !chr_stall;
	assign pop       = (state_q == ST_IDLE) && cmd_valid;
	assign chr_valid = chr_valid_q;
	assign chr_word  = chr_word_q;
	assign nib       = bcd_q[dig_q*4 +: 4];
	assign last_dig  = (dig_q == '0);

	always_comb begin
		for (int i = 0; i < DEC_DIGITS; i++) begin
			bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ?
				bcd_q[i*4 +: 4] + 4'd3 : bcd_q[i*4 +: 4];
		end
	end

	always_comb begin
		top_dig = '0;
		for (int i = 0; i < DEC_DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] != 4'd0) begin
				top_dig = DIG_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					bin_q <= cmd.mag;
					neg_q <= cmd.neg;
					cnt_q <= CNT_W'(VALUE_BITS);
					if (cmd.hex) begin
						bcd_q <= BCD_BITS'(cmd.mag);
						dig_q <= DIG_W'(HEX_DIGITS - 1);
					end else begin
						bcd_q <= '0;
					end
				end
			end
			ST_CONV: begin
				{bcd_q, bin_q} <= {bcd_adj, bin_q} << 1;
				cnt_q          <= cnt_q - 1'b1;
			end
			ST_FIND: begin
				dig_q <= top_dig;
			end
			ST_SIGN: begin
			end
			ST_EMIT: begin
				if (free && !last_dig) begin
					dig_q <= dig_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= cmd.hex ? ST_EMIT : ST_CONV;
					end
				end
				ST_CONV: begin
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_FIND;
					end
				end
				ST_FIND: begin
					state_q <= neg_q ? ST_SIGN : ST_EMIT;
				end
				ST_SIGN: begin
					if (free) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (free && last_dig) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chr_valid_q <= 1'b0;
		end else if (free) begin
			chr_valid_q <= (state_q == ST_SIGN) || (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (free) begin
			if (state_q == ST_SIGN) begin
				chr_word_q.char_code <= CH_MINUS;
				chr_word_q.last      <= 1'b0;
			end else begin
				chr_word_q.char_code <= digit_char_f(nib);
				chr_word_q.last      <= last_dig;
			end
		end
	end

	a_conv_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |-> (cnt_q != '0))
		else $error("conversion with zero shift count");

	a_last_ends_text: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && free && last_dig) |=> (state_q == ST_IDLE && chr_word_q.last))
		else $error("final character did not close the word");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SIGN && free) |=> (chr_valid_q && !chr_word_q.last))
		else $error("minus sign marked last");

endmodule

`default_nettype wire

@@ hw/rtl/integer_to_ascii_formatter_core.sv @@
// Integer to ASCII formatter.
// Input channel val_*: one word holds a value and a format selector
// (unsigned decimal, signed decimal, lowercase hex; selector three acts as hex).
// Output channel chr_*: one word per character, most significant first,
// with last set on the final character of each value's text.
// Both channels: a word moves on a clock edge with valid high and stall low.
// A two-entry command queue sits between the input classifier and the
// character engine, so up to two values are taken while text still goes out.
// Hex: the value is loaded in the idle state, then eight characters go out
// at one per cycle while the output is not stalled. Decimal: the value is
// loaded, the serial binary-to-BCD converter runs one shift-and-adjust step
// per value bit, the leading digit is located, then the characters,
// including the minus sign, go out at one per cycle while not stalled.
// A stalled output holds its character and the engine waits; the queue then
// fills and the input stalls once both entries are taken.
// Reset empties the queue, returns the engine to idle and drops any
// pending output character.
`default_nettype none

module integer_to_ascii_formatter_core
	import i2a_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      val_valid,
	output logic           val_stall,
	input  wire val_word_t val_word,
	output logic           chr_valid,
	input  wire logic      chr_stall,
	output chr_word_t      chr_word
);

	logic push;
	cmd_t push_cmd;
	logic full;
	logic pop;
	logic pop_valid;
	cmd_t pop_cmd;

	i2a_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.val_valid (val_valid),
		.val_stall (val_stall),
		.val_word  (val_word),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full)
	);

	i2a_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_cmd   (pop_cmd)
	);

	i2a_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd       (pop_cmd),
		.pop       (pop),
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.chr_word  (chr_word)
	);

endmodule

`default_nettype wire
